### rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
// Used by the controller, the datapath and the top level; depends on nothing.
package rws_pkg;

   // Fixed field widths of the request and response words.
   localparam int IDX_W    = 10;
   localparam int FIT_IN_W = 32;
   localparam int RAND_W   = 42;
   localparam int OUT_TOT_W = 42;
   localparam int STAT_W   = 2;
   localparam int CFG_W    = 11;

   // Internal sum width; sums wrap modulo 2^64.
   localparam int TOT_W = 64;

   // Reset value of the active entry count register.
   localparam logic [CFG_W-1:0] CFG_RESET = 11'd800;

   // Operation codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;

   // Which kind of response word the controller asks for.
   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_WRITE,
      RSP_EMPTY,
      RSP_HIT,
      RSP_MISS
   } rsp_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch_req;
      logic         walk_init;
      logic         walk_step;
      logic         clear_step;
      logic         wr_read;
      logic         wr_commit;
      logic         total_load;
      rsp_kind_type rsp_kind;
   } rws_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic issued_all;
      logic rd_valid;
      logic hit;
      logic total_zero;
   } rws_sts_type;

endpackage

### rtl/roulette_wheel_selector_unit.sv
// Top level of the roulette wheel selector: controller plus datapath.
// Depends on rws_pkg, rws_ctrl, rws_datapath and rws_ram.
//
//   Channel   Handshake                  Word
//   request   start / busy               req_operation, req_entry_index,
//                                        req_fitness_value, req_random_value
//   response  rsp_strobe (one cycle)     rsp_chosen_index, rsp_fitness_total, rsp_status
//   register  csr_write_enable           csr_write_data (active entry count)
//
// A write word passes through the read and update states before its response strobe is
// registered. A select walks the active entries in order, one RAM read per cycle, and
// responds on the entry whose prefix sum first exceeds the draw, after the whole walk
// for a draw at or above the total, and without walking for an empty wheel.
// After reset the fitness RAM is cleared one entry a cycle, every entry of the table,
// with busy high. A register write raises busy and recomputes the total over
// the new active range. The receiver cannot stall.
module roulette_wheel_selector_unit import rws_pkg::*; #(
   parameter int MAX_ENTRIES  = 1024,
   parameter int FITNESS_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_operation,
   input  logic [IDX_W-1:0]     req_entry_index,
   input  logic [FIT_IN_W-1:0]  req_fitness_value,
   input  logic [RAND_W-1:0]    req_random_value,
   input  logic                 csr_write_enable,
   input  logic [CFG_W-1:0]     csr_write_data,
   output logic                 rsp_strobe,
   output logic [IDX_W-1:0]     rsp_chosen_index,
   output logic [OUT_TOT_W-1:0] rsp_fitness_total,
   output logic [STAT_W-1:0]    rsp_status
);

   rws_cmd_type cmd;
   rws_sts_type sts;

   // Sequencing.
   rws_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_operation    (req_operation),
      .csr_write_enable (csr_write_enable),
      .sts              (sts),
      .busy             (busy),
      .cmd              (cmd)
   );

   // Storage and arithmetic.
   rws_datapath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .FITNESS_BITS (FITNESS_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_entry_index   (req_entry_index),
      .req_fitness_value (req_fitness_value),
      .req_random_value  (req_random_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_fitness_total (rsp_fitness_total),
      .rsp_status        (rsp_status)
   );

endmodule

### rtl/rws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module rws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rws_ctrl.sv
// Controller state machine of the roulette wheel selector.
// Depends on rws_pkg for the command and status structs.
module rws_ctrl import rws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_operation,
   input  logic        csr_write_enable,
   input  rws_sts_type sts,
   output logic        busy,
   output rws_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_UPDATE,
      ST_SELECT,
      ST_RECOMP
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      accept;

   // Busy while working, while a total update is owed, or during a register write.
   assign busy   = (state_ff != ST_IDLE) || pend_ff || csr_write_enable;
   assign accept = start && !busy;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      cmd.rsp_kind = RSP_NONE;

      // A register change outside a sweep owes a recompute of the total.
      if (csr_write_enable && (state_ff != ST_CLEAR) && (state_ff != ST_RECOMP)) begin
         pend_in = 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pend_ff) begin
               cmd.walk_init = 1'b1;
               pend_in       = 1'b0;
               state_in      = ST_RECOMP;
            end else if (accept) begin
               cmd.latch_req = 1'b1;
               cmd.walk_init = 1'b1;
               state_in = (req_operation == OP_WRITE) ? ST_WR_READ : ST_SELECT;
            end
         end
         ST_WR_READ: begin
            cmd.wr_read = 1'b1;
            state_in    = ST_WR_UPDATE;
         end
         ST_WR_UPDATE: begin
            cmd.wr_commit = 1'b1;
            cmd.rsp_kind  = RSP_WRITE;
            state_in      = ST_IDLE;
         end
         ST_SELECT: begin
            cmd.walk_step = 1'b1;
            if (sts.total_zero) begin
               cmd.rsp_kind = RSP_EMPTY;
               state_in     = ST_IDLE;
            end else if (sts.rd_valid && sts.hit) begin
               cmd.rsp_kind = RSP_HIT;
               state_in     = ST_IDLE;
            end else if (sts.issued_all && !sts.rd_valid) begin
               cmd.rsp_kind = RSP_MISS;
               state_in     = ST_IDLE;
            end
         end
         ST_RECOMP: begin
            if (csr_write_enable) begin
               // New active range: start the sweep over.
               cmd.walk_init = 1'b1;
            end else begin
               cmd.walk_step = 1'b1;
               if (sts.issued_all && !sts.rd_valid) begin
                  cmd.total_load = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

### rtl/rws_datapath.sv
// Datapath of the roulette wheel selector: fitness RAM, walk counter,
// prefix sum, running total and response registers. Uses rws_pkg and rws_ram.
module rws_datapath import rws_pkg::*; #(
   parameter int MAX_ENTRIES  = 1024,
   parameter int FITNESS_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rws_cmd_type          cmd,
   output rws_sts_type          sts,
   input  logic [IDX_W-1:0]     req_entry_index,
   input  logic [FIT_IN_W-1:0]  req_fitness_value,
   input  logic [RAND_W-1:0]    req_random_value,
   input  logic                 csr_write_enable,
   input  logic [CFG_W-1:0]     csr_write_data,
   output logic                 rsp_strobe,
   output logic [IDX_W-1:0]     rsp_chosen_index,
   output logic [OUT_TOT_W-1:0] rsp_fitness_total,
   output logic [STAT_W-1:0]    rsp_status
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int NW = $clog2(MAX_ENTRIES + 1);

   // Configuration and latched request.
   logic [CFG_W-1:0]    entries_ff;
   logic [IDX_W-1:0]    req_idx_ff;
   logic [FIT_IN_W-1:0] req_fit_ff;
   logic [RAND_W-1:0]   req_rand_ff;

   // Walk state.
   logic [NW-1:0]    count_ff, count_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [AW-1:0]    rd_idx_ff;
   logic [TOT_W-1:0] prefix_ff, prefix_in;
   logic [TOT_W-1:0] total_ff, total_in;

   // Response registers.
   logic                 rsp_strobe_ff;
   logic [IDX_W-1:0]     rsp_chosen_ff;
   logic [OUT_TOT_W-1:0] rsp_total_ff;
   logic [STAT_W-1:0]    rsp_status_ff;

   logic [NW-1:0]           n_active;
   logic                    idx_ok;
   logic                    idx_active;
   logic                    issue;
   logic [TOT_W-1:0]        fit_ext;
   logic [TOT_W-1:0]        new_ext;
   logic [FITNESS_BITS-1:0] new_fit;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [FITNESS_BITS-1:0] ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [FITNESS_BITS-1:0] ram_rd_data;

   // Active entry count, limited to the table depth.
   always_comb begin
      if (32'(entries_ff) > 32'(MAX_ENTRIES)) begin
         n_active = NW'(MAX_ENTRIES);
      end else begin
         n_active = NW'(entries_ff);
      end
   end

   assign idx_ok     = 32'(req_idx_ff) < 32'(MAX_ENTRIES);
   assign idx_active = 32'(req_idx_ff) < 32'(n_active);
   assign issue      = count_ff < n_active;
   assign new_fit    = FITNESS_BITS'(req_fit_ff);
   assign new_ext    = TOT_W'(new_fit);
   assign fit_ext    = TOT_W'(ram_rd_data);
   assign prefix_in  = prefix_ff + fit_ext;

   // RAM port steering: clearing and write commits share the write port.
   assign ram_wr_en   = cmd.clear_step || (cmd.wr_commit && idx_ok);
   assign ram_wr_addr = cmd.clear_step ? count_ff[AW-1:0] : AW'(req_idx_ff);
   assign ram_wr_data = cmd.clear_step ? '0 : new_fit;
   assign ram_rd_addr = cmd.wr_read ? AW'(req_idx_ff) : count_ff[AW-1:0];

   rws_ram #(
      .WIDTH (FITNESS_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Walk counter, read-valid flag, prefix sum and running total.
   always_comb begin
      count_in    = count_ff;
      rd_valid_in = 1'b0;
      total_in    = total_ff;
      if (cmd.walk_init) begin
         count_in = '0;
      end else if ((cmd.walk_step && issue) || cmd.clear_step) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.walk_step && !cmd.walk_init) begin
         rd_valid_in = issue;
      end
      if (cmd.total_load) begin
         total_in = prefix_ff;
      end else if (cmd.wr_commit && idx_active) begin
         total_in = total_ff - fit_ext + new_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff    <= CFG_RESET;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            entries_ff <= csr_write_data;
         end
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= (cmd.rsp_kind != RSP_NONE);
      end
   end

   // Payload registers: request word, walk index and prefix sum.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_idx_ff  <= req_entry_index;
         req_fit_ff  <= req_fitness_value;
         req_rand_ff <= req_random_value;
      end
      rd_idx_ff <= count_ff[AW-1:0];
      if (cmd.walk_init) begin
         prefix_ff <= '0;
      end else if (rd_valid_ff) begin
         prefix_ff <= prefix_in;
      end
   end

   // Response word.
   always_ff @(posedge clock) begin
      rsp_total_ff <= total_in[OUT_TOT_W-1:0];
      unique case (cmd.rsp_kind)
         RSP_HIT: begin
            rsp_chosen_ff <= IDX_W'(rd_idx_ff);
            rsp_status_ff <= STAT_OK;
         end
         RSP_EMPTY: begin
            rsp_chosen_ff <= '0;
            rsp_status_ff <= STAT_EMPTY;
         end
         RSP_MISS: begin
            rsp_chosen_ff <= '0;
            rsp_status_ff <= STAT_MISS;
         end
         default: begin
            rsp_chosen_ff <= '0;
            rsp_status_ff <= STAT_OK;
         end
      endcase
   end

   // Status toward the controller.
   always_comb begin
      sts.clear_last = (count_ff == NW'(MAX_ENTRIES - 1));
      sts.issued_all = !issue;
      sts.rd_valid   = rd_valid_ff;
      sts.hit        = TOT_W'(req_rand_ff) < prefix_in;
      sts.total_zero = (total_ff == '0);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_chosen_index  = rsp_chosen_ff;
   assign rsp_fitness_total = rsp_total_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

### sim/tb_roulette_wheel_selector_unit.sv
// Self-checking testbench for roulette_wheel_selector_unit: directed and random request words
// under several active entry counts, with every response checked against a predicted wheel.
// Depends on rws_pkg and the roulette_wheel_selector_unit RTL.
module tb_roulette_wheel_selector_unit import rws_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 1024;
   localparam int NUM_PHASES  = 10;

   // One predicted response word.
   typedef struct packed {
      logic [IDX_W-1:0]     chosen;
      logic [OUT_TOT_W-1:0] total;
      logic [STAT_W-1:0]    status;
   } wheel_result_type;

   // Keeps its own copy of the fitness table and the active count, predicts the response
   // word of each accepted request and compares arriving responses in order.
   class roulette_checker_type;
      bit [FIT_IN_W-1:0] weight [TABLE_DEPTH];
      int unsigned       active;
      bit [TOT_W-1:0]    total;
      wheel_result_type  awaited_results [$];
      int                failures;
      int                n_write, n_hit, n_empty, n_miss, n_settings;

      function new();
         foreach (weight[i]) weight[i] = '0;
         active     = CFG_RESET;
         total      = '0;
         failures   = 0;
         n_write    = 0;
         n_hit      = 0;
         n_empty    = 0;
         n_miss     = 0;
         n_settings = 0;
      endfunction

      // A new active count clamps to the table depth and rebuilds the total.
      function void set_active_count(logic [CFG_W-1:0] value);
         active = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
         total  = '0;
         for (int i = 0; i < active; i++) total += weight[i];
         n_settings++;
      endfunction

      function void record_request(logic op, logic [IDX_W-1:0] idx,
                                   logic [FIT_IN_W-1:0] fit, logic [RAND_W-1:0] r);
         wheel_result_type res;
         bit [TOT_W-1:0]   prefix;
         bit               found;
         res = '0;
         if (op == OP_WRITE) begin
            if (idx < active) total = total - weight[idx] + fit;
            weight[idx] = fit;
            n_write++;
         end else if (total == 0) begin
            res.status = STAT_EMPTY;
            n_empty++;
         end else begin
            // Walk the active entries until the draw falls below the prefix sum.
            prefix = '0;
            found  = 1'b0;
            for (int i = 0; i < active && !found; i++) begin
               prefix += weight[i];
               if (r < prefix) begin
                  res.chosen = IDX_W'(i);
                  found      = 1'b1;
               end
            end
            if (found) begin
               res.status = STAT_OK;
               n_hit++;
            end else begin
               res.status = STAT_MISS;
               n_miss++;
            end
         end
         res.total = total[OUT_TOT_W-1:0];
         awaited_results.insert(awaited_results.size(), res);
      endfunction

      function void check_response(logic [IDX_W-1:0] chosen, logic [OUT_TOT_W-1:0] tot,
                                   logic [STAT_W-1:0] status);
         wheel_result_type want;
         if (awaited_results.size() == 0) begin
            $error("response word with no request outstanding: index %0d total 0x%0h status %0d",
                   chosen, tot, status);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         if (chosen !== want.chosen) begin
            $error("chosen_index mismatch: expected %0d, actual %0d", want.chosen, chosen);
            failures++;
         end
         if (tot !== want.total) begin
            $error("fitness_total mismatch: expected 0x%0h, actual 0x%0h", want.total, tot);
            failures++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            failures++;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_operation = OP_WRITE;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic [FIT_IN_W-1:0]  req_fitness_value = '0;
   logic [RAND_W-1:0]    req_random_value = '0;
   logic                 csr_write_enable = 1'b0;
   logic [CFG_W-1:0]     csr_write_data = '0;
   logic                 rsp_strobe;
   logic [IDX_W-1:0]     rsp_chosen_index;
   logic [OUT_TOT_W-1:0] rsp_fitness_total;
   logic [STAT_W-1:0]    rsp_status;

   roulette_checker_type wheel = new();

   int phase_setting [NUM_PHASES] = '{4, 16, 2047, 0, 7, 1024, 3, 32, 2, 1};
   int burst_left = 0;

   roulette_wheel_selector_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_fitness_value (req_fitness_value),
      .req_random_value  (req_random_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_fitness_total (rsp_fitness_total),
      .rsp_status        (rsp_status)
   );

   always #2 clock = ~clock;

   // Present one request word and hold it until the block takes it.
   task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [FIT_IN_W-1:0] fit, input logic [RAND_W-1:0] r);
      start             <= 1'b1;
      req_operation     <= op;
      req_entry_index   <= idx;
      req_fitness_value <= fit;
      req_random_value  <= r;
      do @(posedge clock); while (busy !== 1'b0);
      wheel.record_request(op, idx, fit, r);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Change the active count only once the block has drained and gone idle.
   task automatic write_active_count(input logic [CFG_W-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (wheel.pending() != 0 || busy !== 1'b0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wheel.set_active_count(value);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   function automatic logic [FIT_IN_W-1:0] draw_fitness();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return $urandom;
      else if (pick < 7) return $urandom_range(0, 255);
      else if (pick < 9) return '0;
      else return '1;
   endfunction

   // Mostly draws in range, with the boundary at the total and wide draws mixed in.
   function automatic logic [RAND_W-1:0] draw_spin();
      logic [63:0] wide;
      int          pick;
      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick < 15 && wheel.total != 0) return RAND_W'(wide % wheel.total);
      else if (pick < 17) return wheel.total[RAND_W-1:0];
      else if (pick == 17 && wheel.total != 0) return wheel.total[RAND_W-1:0] - 1'b1;
      else return wide[RAND_W-1:0];
   endfunction

   // Random phase: fill the wheel first, then mix writes and selects in bursts.
   task automatic run_random_phase(input int count);
      logic                op;
      logic [IDX_W-1:0]    idx;
      logic [FIT_IN_W-1:0] fit;
      logic [RAND_W-1:0]   r;
      for (int k = 0; k < count; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
         end
         burst_left--;
         op = ($urandom_range(0, 99) < ((k < 8) ? 10 : 50)) ? OP_SELECT : OP_WRITE;
         if ($urandom_range(0, 9) < 7 && wheel.active > 0)
            idx = IDX_W'($urandom_range(0, wheel.active - 1));
         else
            idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
         fit = draw_fitness();
         r   = (op == OP_SELECT) ? draw_spin() : RAND_W'({$urandom, $urandom});
         send_word(op, idx, fit, r);
      end
   endtask

   // Check every response word as it goes by.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         wheel.check_response(rsp_chosen_index, rsp_fitness_total, rsp_status);
   end

   // Main sequence: reset, directed words, random phases, drain and verdict.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty wheel under the reset count, then edges of the active range.
      send_word(OP_SELECT, '0, '0, '0);
      send_word(OP_SELECT, '1, '1, '1);
      send_word(OP_WRITE, 10'd0, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, 10'd1023, 32'hFFFF_FFFF, '0);
      send_word(OP_WRITE, 10'd799, 32'd1, '0);
      send_word(OP_WRITE, 10'd800, 32'd5, '0);
      send_word(OP_SELECT, '0, '0, 42'h0);
      send_word(OP_SELECT, '0, '0, 42'h0_FFFF_FFFE);
      send_word(OP_SELECT, '0, '0, 42'h0_FFFF_FFFF);
      send_word(OP_SELECT, '0, '0, 42'h1_0000_0000);
      send_word(OP_SELECT, '0, '0, '1);
      send_word(OP_WRITE, 10'd0, 32'd0, '0);
      send_word(OP_SELECT, '0, '0, 42'h0);
      send_word(OP_WRITE, 10'h155, 32'hAAAA_AAAA, '0);
      send_word(OP_WRITE, 10'h2AA, 32'h5555_5555, '0);
      send_word(OP_SELECT, '0, '0, 42'h0_AAAA_AAAA);
      send_word(OP_SELECT, '0, '0, 42'h0_AAAA_AAA9);

      // Count above the table, then no active entries, then a single entry.
      write_active_count(11'h7FF);
      send_word(OP_SELECT, '0, '0, wheel.total[RAND_W-1:0] - 1'b1);
      write_active_count(11'd0);
      send_word(OP_SELECT, '0, '0, 42'h0);
      send_word(OP_WRITE, 10'd0, 32'd3, '0);
      write_active_count(11'd1);
      send_word(OP_WRITE, 10'd0, 32'd7, '0);
      send_word(OP_SELECT, '0, '0, 42'd6);
      send_word(OP_SELECT, '0, '0, 42'd7);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_active_count(CFG_W'(phase_setting[p]));
         run_random_phase((phase_setting[p] > 64) ? 30 : 55);
      end

      start <= 1'b0;
      @(posedge clock);
      while (wheel.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Run covered %0d writes and %0d selects over %0d active-count settings.",
               wheel.n_write, wheel.n_hit + wheel.n_empty + wheel.n_miss, wheel.n_settings);
      $display("Selects: %0d landed on an entry, %0d hit an empty wheel, %0d drew past the total.",
               wheel.n_hit, wheel.n_empty, wheel.n_miss);
      if (wheel.failures == 0 && wheel.pending() == 0) begin
         $display("** roulette_wheel_selector_unit: PASSED **");
      end else begin
         $display("** roulette_wheel_selector_unit: FAILED **");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Timed out with %0d response words still awaited.", wheel.pending());
      $display("** roulette_wheel_selector_unit: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/rws_pkg.sv
rtl/rws_ram.sv
rtl/rws_ctrl.sv
rtl/rws_datapath.sv
rtl/roulette_wheel_selector_unit.sv
sim/tb_roulette_wheel_selector_unit.sv
